[src/ble_injection_interval_detector_unit_assert.svh]
// assertion macros shared by the rtl
`ifndef BLE_INJECTION_INTERVAL_DETECTOR_UNIT_ASSERT_SVH
`define BLE_INJECTION_INTERVAL_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define BLEIID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bleiid assertion failed");

// next-cycle implication, off during reset
`define BLEIID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bleiid assertion failed");

`endif

[src/bleiid_pkg.sv]
package bleiid_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LIMIT_W       = 23;
    localparam logic [10:0] US_PER_UNIT = 11'd1250;

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_ALERT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] access_address;
        logic [31:0] event_time_us;
        logic [15:0] event_number;
        logic [11:0] interval_units;
    } evt_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alert_address;
    } alert_item_t;

endpackage

[src/bleiid_evt_if.sv]
interface bleiid_evt_if import bleiid_pkg::*; ();
    logic      valid;
    logic      ready;
    evt_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/bleiid_alert_if.sv]
interface bleiid_alert_if import bleiid_pkg::*; ();
    logic        valid;
    logic        ready;
    alert_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/ble_injection_interval_detector_unit.sv]
// ble connection event injection check
// events (sink): one item per observed connection event, carrying access
//   address, microsecond timestamp, event counter and interval in 1.25 ms units
// alerts (source): exactly one item per event, status none / alert / table full,
//   plus the access address of that event
// an item is moved when valid and ready are both high at a rising clk edge
// timing: an event is taken only while the sequencer is idle; it then steps
//   through match, read, difference, magnitude, compare and result for a new
//   counter, skips magnitude and compare for an unchanged counter and goes
//   from read to the result for a new address in a full table; it returns to
//   idle as the result goes valid; one shared 33-bit subtractor forms the time
//   difference, its magnitude and the compare against interval*1250 in turn
// reset (rst_n, async, active low) clears all entry valid bits, the sequencer
//   and the output valid; entry contents are written before they are read
// a stalled receiver holds the result in the output register; the block
//   finishes the current event and then waits before taking another
`include "ble_injection_interval_detector_unit_assert.svh"

module ble_injection_interval_detector_unit import bleiid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bleiid_evt_if.sink       events,
    bleiid_alert_if.source   alerts
);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIFF  = 3'd3;
    localparam logic [2:0] S_ABS   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    // event under work
    evt_item_t item_reg;

    // lookup table: addresses in flops for the parallel match,
    // timestamp and counter in a small memory read at the chosen slot
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0]              addr_reg [TABLE_ENTRIES];
    logic [47:0]              slot_mem [TABLE_ENTRIES];
    logic [47:0]              rd_reg;

    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic                     any_hit;
    logic                     any_free;

    logic                     hit_reg;
    logic                     full_reg;
    logic [IDX_W-1:0]         slot_reg;

    logic [LIMIT_W-1:0]       limit_reg;
    logic [31:0]              acc_reg;
    logic [1:0]               status_reg;

    // stored values seen by this event (a fresh entry starts at zero)
    logic [31:0]              last_time;
    logic [15:0]              last_evn;
    logic                     evn_ne;
    logic                     mem_we;

    // shared subtractor
    logic [31:0]              sub_a;
    logic [31:0]              sub_b;
    logic [32:0]              sub_res;

    alert_item_t              out_reg;
    logic                     out_valid_reg;
    logic                     out_load;

    // ---------------------------------------------------------------
    // address match and free slot search
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (addr_reg[i] == item_reg.access_address);
        end
    end

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        any_hit  = 1'b0;
        any_free = 1'b0;
        // descending scan leaves the lowest index
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
                any_hit = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign last_time = hit_reg ? rd_reg[47:16] : 32'd0;
    assign last_evn  = hit_reg ? rd_reg[15:0]  : 16'd0;
    assign evn_ne    = (last_evn != item_reg.event_number);
    // a new entry is written even when its counter already matches zero
    assign mem_we    = (state_reg == S_DIFF) && (!hit_reg || evn_ne);

    // ---------------------------------------------------------------
    // shared subtractor: difference, magnitude, compare
    // ---------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_DIFF:
            begin
                sub_a = item_reg.event_time_us;
                sub_b = last_time;
            end
            S_ABS:
            begin
                sub_a = 32'd0;
                sub_b = acc_reg;
            end
            S_CMP:
            begin
                sub_a = acc_reg;
                sub_b = {{(32 - LIMIT_W){1'b0}}, limit_reg};
            end
            default:
            begin
                sub_a = 32'd0;
                sub_b = 32'd0;
            end
        endcase
    end

    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || alerts.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (events.valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                // a new address in a full table goes straight to the result
                state_next = (!hit_reg && full_reg) ? S_DONE : S_DIFF;
            end
            S_DIFF:
            begin
                state_next = evn_ne ? S_ABS : S_DONE;
            end
            S_ABS:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign events.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we && !hit_reg)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (alerts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            item_reg <= events.data;
        end

        case (state_reg)
            S_MATCH:
            begin
                hit_reg  <= any_hit;
                full_reg <= !any_free;
                slot_reg <= any_hit ? hit_idx : free_idx;
            end
            S_READ:
            begin
                rd_reg     <= slot_mem[slot_reg];
                limit_reg  <= LIMIT_W'(item_reg.interval_units) * LIMIT_W'(US_PER_UNIT);
                status_reg <= STATUS_FULL;
            end
            S_DIFF:
            begin
                acc_reg    <= sub_res[31:0];
                status_reg <= STATUS_NONE;
            end
            S_ABS:
            begin
                // negate when negative; the most negative value keeps 2^31
                if (acc_reg[31])
                begin
                    acc_reg <= sub_res[31:0];
                end
            end
            S_CMP:
            begin
                // borrow means distance below the interval
                status_reg <= sub_res[32] ? STATUS_ALERT : STATUS_NONE;
            end
            default:
            begin
            end
        endcase

        if (mem_we)
        begin
            slot_mem[slot_reg] <= {evn_ne ? item_reg.event_time_us : 32'd0,
                                   item_reg.event_number};
            if (!hit_reg)
            begin
                addr_reg[slot_reg] <= item_reg.access_address;
            end
        end

        if (out_load)
        begin
            out_reg.status        <= status_reg;
            out_reg.alert_address <= item_reg.access_address;
        end
    end

    assign alerts.valid = out_valid_reg;
    assign alerts.data  = out_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // an access address lives in at most one entry
    `BLEIID_ASSERT_NOW(a_unique_match, state_reg == S_MATCH, $onehot0(match_vec))
    // entries are never freed and at most one is claimed per cycle
    `BLEIID_ASSERT_NEXT(a_valid_grows, 1'b1,
        ($countones(valid_reg) >= $past($countones(valid_reg))) &&
        ($countones(valid_reg) <= $past($countones(valid_reg)) + 1))
    // an accepted event starts the lookup
    `BLEIID_ASSERT_NEXT(a_accept_starts, events.valid && events.ready, state_reg == S_MATCH)
    // a full report only when every entry is taken
    `BLEIID_ASSERT_NOW(a_full_only_when_full,
        (state_reg == S_DONE) && (status_reg == STATUS_FULL), &valid_reg)

endmodule
